// ===== src/trm_pkg.sv =====
// ============================================================================
// trm_pkg : shared types and constants of the register machine execute block
// action codes, error codes, flag positions, stack sizing and bus structs
// ============================================================================
package trm_pkg;

  localparam int WORD_W      = 32;
  localparam int NUM_REGS    = 32;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int FLAGS_W     = 4;
  localparam int LINE_W      = 7;
  localparam int NEXT_W      = 8;
  localparam int PLINES_W    = 8;
  localparam int ACTION_W    = 5;
  localparam int ERR_W       = 2;

  localparam int STACK_DEPTH = 128;
  localparam int MAX_LINES   = 128;
  localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int STK_ADDR_W  = $clog2(STACK_DEPTH);

  localparam logic [PLINES_W-1:0] PLINES_RESET = PLINES_W'(128);

  // flag bit positions
  localparam int FLAG_PAR  = 0;
  localparam int FLAG_ZERO = 1;
  localparam int FLAG_NEG  = 2;
  localparam int FLAG_OVF  = 3;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 5'd0,
    ACT_SUB    = 5'd1,
    ACT_AND    = 5'd2,
    ACT_XOR    = 5'd3,
    ACT_OR     = 5'd4,
    ACT_ADDI   = 5'd5,
    ACT_SUBI   = 5'd6,
    ACT_ANDI   = 5'd7,
    ACT_XORI   = 5'd8,
    ACT_ORI    = 5'd9,
    ACT_SWAP   = 5'd10,
    ACT_SKIPEQ = 5'd11,
    ACT_PUSH   = 5'd12,
    ACT_POP    = 5'd13,
    ACT_MOVREG = 5'd14,
    ACT_MOVIMM = 5'd15,
    ACT_JUMP   = 5'd16,
    ACT_INPUT  = 5'd17,
    ACT_OUTPUT = 5'd18,
    ACT_EXIT   = 5'd19
  } action_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_JUMP  = 2'd3
  } err_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    word_t data;
  } stack_cmd_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [STK_CNT_W-1:0] count;
    word_t                tos;
  } stack_stat_t;

endpackage

// ===== src/trm_ram.sv =====
// ============================================================================
// trm_ram : generic single write, single read ram
// one write port, one read port with registered read data
// ============================================================================
module trm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/trm_alu.sv =====
// ============================================================================
// trm_alu : arithmetic and logic unit
// add, sub, and, xor, or on two words, with status flag update
// ============================================================================
module trm_alu (
  input  trm_pkg::action_t             action,
  input  trm_pkg::word_t               a,
  input  trm_pkg::word_t               b,
  input  logic [trm_pkg::FLAGS_W-1:0]  flags_in,
  output trm_pkg::word_t               result,
  output logic [trm_pkg::FLAGS_W-1:0]  flags_out,
  output logic                         is_alu
);
  import trm_pkg::*;

  word_t sum;
  word_t diff;
  logic  ovf;

  always_comb begin
    sum    = a + b;
    diff   = a - b;
    result = '0;
    ovf    = flags_in[FLAG_OVF];
    is_alu = 1'b1;
    case (action)
      ACT_ADD, ACT_ADDI: begin
        result = sum;
        ovf    = (a[WORD_W-1] ^ sum[WORD_W-1]) & (b[WORD_W-1] ^ sum[WORD_W-1]);
      end
      ACT_SUB, ACT_SUBI: begin
        result = diff;
        ovf    = (a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ diff[WORD_W-1]);
      end
      ACT_AND, ACT_ANDI: result = a & b;
      ACT_XOR, ACT_XORI: result = a ^ b;
      ACT_OR,  ACT_ORI:  result = a | b;
      default:           is_alu = 1'b0;
    endcase
    if (is_alu) begin
      flags_out            = '0;
      flags_out[FLAG_PAR]  = ^result;
      flags_out[FLAG_ZERO] = (result == '0);
      flags_out[FLAG_NEG]  = result[WORD_W-1];
      flags_out[FLAG_OVF]  = ovf;
    end else begin
      flags_out = flags_in;
    end
  end

endmodule

// ===== src/trm_stack.sv =====
// ============================================================================
// trm_stack : push-down stack with top held in a register
// top of stack in flops, lower entries in ram, entry below top prefetched
// ============================================================================
module trm_stack (
  input  logic                  clk,
  input  logic                  rst_n,
  input  trm_pkg::stack_cmd_t   cmd,
  output trm_pkg::stack_stat_t  stat
);
  import trm_pkg::*;

  logic [STK_CNT_W-1:0]  count_r;
  logic [STK_CNT_W-1:0]  count_nxt;
  word_t                 tos_r;
  word_t                 tos_nxt;
  logic                  byp_sel_r;
  word_t                 byp_data_r;
  word_t                 ram_rdata;
  word_t                 below;
  logic                  full;
  logic                  empty;
  logic                  do_push;
  logic                  do_pop;
  logic                  ram_we;
  logic [STK_CNT_W-1:0]  cnt_m1;
  logic [STK_CNT_W-1:0]  cnt_nxt_m2;

  assign full       = (count_r == STK_CNT_W'(STACK_DEPTH));
  assign empty      = (count_r == '0);
  assign do_push    = cmd.push & ~full;
  assign do_pop     = cmd.pop & ~empty;
  assign cnt_m1     = count_r - STK_CNT_W'(1);
  assign cnt_nxt_m2 = count_nxt - STK_CNT_W'(2);
  // old top moves into ram when a push lands on a non-empty stack
  assign ram_we     = do_push & ~empty;
  // entry just below the top, valid whenever count is two or more
  assign below      = byp_sel_r ? byp_data_r : ram_rdata;

  always_comb begin
    count_nxt = count_r;
    tos_nxt   = tos_r;
    if (do_push) begin
      count_nxt = count_r + STK_CNT_W'(1);
      tos_nxt   = cmd.data;
    end else if (do_pop) begin
      count_nxt = cnt_m1;
      tos_nxt   = below;
    end
  end

  trm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[STK_ADDR_W-1:0]),
    .wdata (tos_r),
    .raddr (cnt_nxt_m2[STK_ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      byp_sel_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      byp_sel_r <= do_push;
    end
  end

  // on a push the new below-top is the old top, which the ram read misses
  always_ff @(posedge clk) begin
    tos_r      <= tos_nxt;
    byp_data_r <= tos_r;
  end

  assign stat.full  = full;
  assign stat.empty = empty;
  assign stat.count = count_r;
  assign stat.tos   = tos_r;

endmodule

// ===== src/toy_register_machine_execute.sv =====
// ============================================================================
// toy_register_machine_execute : one decoded instruction per item
// register file, status flags, stack and next line computation
// ============================================================================
// path: an accepted item is held in the input register, then executed into the
//   result register that drives out_valid
// throughput: one item per cycle unless out_ready stalls the result register, set by
//   the single execute stage that reads and writes the register file, flags and stack top in the same cycle
// reset: registers, flags and stack count cleared, program_lines set to 128;
//   no clearing pass, stack ram contents are left as they are
module toy_register_machine_execute (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [trm_pkg::PLINES_W-1:0]     cfg_program_lines,
  // instruction items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [trm_pkg::ACTION_W-1:0]     in_action,
  input  logic [trm_pkg::REG_IDX_W-1:0]    in_dest_reg,
  input  logic [trm_pkg::REG_IDX_W-1:0]    in_src_reg,
  input  logic [trm_pkg::REG_IDX_W-1:0]    in_src2_reg,
  input  logic signed [trm_pkg::WORD_W-1:0] in_immediate,
  input  logic [trm_pkg::LINE_W-1:0]       in_line_index,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [trm_pkg::NEXT_W-1:0]       out_next_line,
  output logic                             out_halt,
  output logic                             out_shows_value,
  output logic signed [trm_pkg::WORD_W-1:0] out_out_value,
  output logic [trm_pkg::FLAGS_W-1:0]      out_flags,
  output logic [trm_pkg::ERR_W-1:0]        out_error_code
);
  import trm_pkg::*;

  // ---------------- configuration ----------------
  logic [PLINES_W-1:0] plines_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plines_r <= PLINES_RESET;
    end else if (cfg_valid) begin
      plines_r <= cfg_program_lines;
    end
  end

  // ---------------- input register ----------------
  logic                 stg_valid_r;
  action_t              stg_action_r;
  logic [REG_IDX_W-1:0] stg_dest_r;
  logic [REG_IDX_W-1:0] stg_src_r;
  logic [REG_IDX_W-1:0] stg_src2_r;
  word_t                stg_imm_r;
  logic [LINE_W-1:0]    stg_line_r;
  logic                 adv;
  logic                 out_valid_r;

  // the stage moves on when the output register is empty or being drained
  assign adv      = stg_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~stg_valid_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_action_r <= action_t'(in_action);
      stg_dest_r   <= in_dest_reg;
      stg_src_r    <= in_src_reg;
      stg_src2_r   <= in_src2_reg;
      stg_imm_r    <= word_t'(in_immediate);
      stg_line_r   <= in_line_index;
    end
  end

  // ---------------- architectural state ----------------
  word_t              rf_r [NUM_REGS];
  word_t              rf_nxt [NUM_REGS];
  logic [FLAGS_W-1:0] flags_r;
  logic [FLAGS_W-1:0] flags_nxt;

  // operand reads: immediate forms take the immediate as second operand
  word_t op_a;
  word_t op_b;
  word_t rd_dest;
  word_t rd_reg0;
  logic  imm_form;

  always_comb begin
    imm_form = stg_action_r inside {[ACT_ADDI:ACT_ORI]};
  end

  assign op_a    = rf_r[stg_src_r];
  assign op_b    = imm_form ? stg_imm_r : rf_r[stg_src2_r];
  assign rd_dest = rf_r[stg_dest_r];
  assign rd_reg0 = rf_r[0];

  // ---------------- alu ----------------
  word_t              alu_res;
  logic [FLAGS_W-1:0] alu_flags;
  logic               alu_op;

  trm_alu u_alu (
    .action    (stg_action_r),
    .a         (op_a),
    .b         (op_b),
    .flags_in  (flags_r),
    .result    (alu_res),
    .flags_out (alu_flags),
    .is_alu    (alu_op)
  );

  // ---------------- stack ----------------
  stack_cmd_t  stk_cmd;
  stack_stat_t stk_stat;

  assign stk_cmd.push = adv & (stg_action_r == ACT_PUSH);
  assign stk_cmd.pop  = adv & (stg_action_r == ACT_POP);
  assign stk_cmd.data = rd_dest;

  trm_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat)
  );

  // ---------------- jump range check ----------------
  word_t plines_w;
  word_t jump_limit;
  logic  jump_bad;

  // limit is program_lines, clamped to the program store size
  assign plines_w   = WORD_W'(plines_r);
  assign jump_limit = (plines_w > WORD_W'(MAX_LINES)) ? WORD_W'(MAX_LINES) : plines_w;
  assign jump_bad   = stg_imm_r[WORD_W-1] | (stg_imm_r == '0) | (stg_imm_r > jump_limit);

  // ---------------- execute ----------------
  logic [NEXT_W-1:0]    next_line;
  logic                 halt;
  logic                 shows;
  word_t                show_val;
  err_t                 err;
  logic                 we0;
  logic [REG_IDX_W-1:0] wa0;
  word_t                wd0;
  logic                 we1;
  logic [NEXT_W-1:0]    line_ext;

  assign line_ext = NEXT_W'(stg_line_r);

  always_comb begin
    next_line = line_ext + NEXT_W'(1);
    halt      = 1'b0;
    shows     = 1'b0;
    show_val  = '0;
    err       = ERR_NONE;
    we0       = 1'b0;
    wa0       = stg_dest_r;
    wd0       = alu_res;
    we1       = 1'b0;
    case (stg_action_r)
      ACT_ADD, ACT_SUB, ACT_AND, ACT_XOR, ACT_OR,
      ACT_ADDI, ACT_SUBI, ACT_ANDI, ACT_XORI, ACT_ORI: begin
        we0 = alu_op;
      end
      ACT_SWAP: begin
        // dest takes src, src takes old dest on the second port
        we0 = 1'b1;
        wd0 = op_a;
        we1 = 1'b1;
      end
      ACT_SKIPEQ: begin
        if (rd_dest == op_a) begin
          next_line = line_ext + NEXT_W'(2);
        end
      end
      ACT_PUSH: begin
        if (stk_stat.full) begin
          err = ERR_FULL;
        end
      end
      ACT_POP: begin
        if (stk_stat.empty) begin
          err = ERR_EMPTY;
        end else begin
          we0 = 1'b1;
          wd0 = stk_stat.tos;
        end
      end
      ACT_MOVREG: begin
        we0 = 1'b1;
        wd0 = op_a;
      end
      ACT_MOVIMM: begin
        we0 = 1'b1;
        wd0 = stg_imm_r;
      end
      ACT_JUMP: begin
        if (jump_bad) begin
          err = ERR_JUMP;
        end else begin
          next_line = stg_imm_r[NEXT_W-1:0] - NEXT_W'(1);
        end
      end
      ACT_INPUT: begin
        we0 = 1'b1;
        wa0 = '0;
        wd0 = stg_imm_r;
      end
      ACT_OUTPUT: begin
        shows    = 1'b1;
        show_val = rd_reg0;
      end
      ACT_EXIT: begin
        halt      = 1'b1;
        next_line = line_ext;
      end
      default: begin
        // unused action codes fall through as a plain step
      end
    endcase
  end

  // register file and flag next state; writes land only when the item moves on
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      rf_nxt[i] = rf_r[i];
    end
    if (adv && we0) begin
      rf_nxt[wa0] = wd0;
    end
    if (adv && we1) begin
      rf_nxt[stg_src_r] = rd_dest;
    end
    flags_nxt = adv ? alu_flags : flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
      flags_r <= '0;
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= rf_nxt[i];
      end
      flags_r <= flags_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [NEXT_W-1:0]  out_next_line_r;
  logic               out_halt_r;
  logic               out_shows_r;
  word_t              out_value_r;
  logic [FLAGS_W-1:0] out_flags_r;
  err_t               out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_next_line_r <= next_line;
      out_halt_r      <= halt;
      out_shows_r     <= shows;
      out_value_r     <= show_val;
      out_flags_r     <= alu_flags;
      out_err_r       <= err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_line   = out_next_line_r;
  assign out_halt        = out_halt_r;
  assign out_shows_value = out_shows_r;
  assign out_out_value   = out_value_r;
  assign out_flags       = out_flags_r;
  assign out_error_code  = out_err_r;

  // ---------------- assertions ----------------
  // exit reports its own line and halts
  a_exit_line: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (stg_action_r == ACT_EXIT) |=>
      out_halt && (out_next_line == NEXT_W'($past(stg_line_r))))
    else $error("exit result does not hold its own line");

  // a push on a full stack leaves the stack count alone
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.push && stk_stat.full |=> $stable(stk_stat.count))
    else $error("push on full stack changed the count");

  // a failed pop reports empty and writes nothing (checked on register 0)
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.pop && stk_stat.empty |=> (out_error_code == ERR_EMPTY) && $stable(rf_r[0]))
    else $error("pop on empty stack misreported");

  // the shown value is zero unless the item is an output
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_shows_value |-> (out_out_value == '0))
    else $error("value shown on a non-output item");

endmodule

// ===== test/tb.sv =====
// ============================================================================
// tb : testbench of the register machine execute block
// a directed table then random instruction streams in several program-length
// phases; every result is compared with an in-bench instruction executor, or
// with the typed outcome of a table row where that row gives one
module tb;
  import trm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 242;
  localparam int NUM_ROWS    = 28;

  // action codes above exit do nothing but advance the line
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 5'd31;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 5'd20;

  // flag masks built from the package bit positions
  localparam logic [FLAGS_W-1:0] F_PAR  = 4'b1 << FLAG_PAR;
  localparam logic [FLAGS_W-1:0] F_ZERO = 4'b1 << FLAG_ZERO;
  localparam logic [FLAGS_W-1:0] F_NEG  = 4'b1 << FLAG_NEG;
  localparam logic [FLAGS_W-1:0] F_OVF  = 4'b1 << FLAG_OVF;

  localparam word_t W_MAX = 32'h7FFF_FFFF;
  localparam word_t W_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [NEXT_W-1:0]  next_line;
    logic               halt;
    logic               shows;
    word_t              value;
    logic [FLAGS_W-1:0] flags;
    logic [ERR_W-1:0]   err;
  } outcome_t;

  // one row of the directed table; the typed outcome is used only when known
  typedef struct packed {
    logic [ACTION_W-1:0]  act;
    logic [REG_IDX_W-1:0] dst;
    logic [REG_IDX_W-1:0] src;
    logic [REG_IDX_W-1:0] src2;
    word_t                imm;
    logic [LINE_W-1:0]    line;
    logic                 known;
    outcome_t             res;
  } instr_row_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [PLINES_W-1:0] cfg_program_lines;
  logic in_valid, in_ready;
  logic [ACTION_W-1:0] in_action;
  logic [REG_IDX_W-1:0] in_dest_reg, in_src_reg, in_src2_reg;
  logic signed [WORD_W-1:0] in_immediate;
  logic [LINE_W-1:0] in_line_index;
  logic out_valid, out_ready;
  logic [NEXT_W-1:0] out_next_line;
  logic out_halt, out_shows_value;
  logic signed [WORD_W-1:0] out_out_value;
  logic [FLAGS_W-1:0] out_flags;
  logic [ERR_W-1:0] out_error_code;

  // typed outcome travelling with the item currently offered
  logic     row_known;
  outcome_t row_res;

  toy_register_machine_execute u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_program_lines (cfg_program_lines),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_dest_reg       (in_dest_reg),
    .in_src_reg        (in_src_reg),
    .in_src2_reg       (in_src2_reg),
    .in_immediate      (in_immediate),
    .in_line_index     (in_line_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_line     (out_next_line),
    .out_halt          (out_halt),
    .out_shows_value   (out_shows_value),
    .out_out_value     (out_out_value),
    .out_flags         (out_flags),
    .out_error_code    (out_error_code)
  );

  // executor state: registers, status flags, stack and program length
  word_t              gpr [NUM_REGS];
  logic [FLAGS_W-1:0] sr_flags;
  word_t              stk_mem [STACK_DEPTH];
  int                 stk_cnt;
  logic [PLINES_W-1:0] line_limit;

  outcome_t pending_outcomes [$];
  outcome_t want, got;

  int  n_sent, n_checked, n_bad, cyc;
  int  n_full, n_empty, n_jerr, n_skip, n_halt;
  bit  steady;

  instr_row_t instr_rows [NUM_ROWS] = '{
    // right after reset: output of register 0, pop on empty stack
    '{ACT_OUTPUT, 5'd0, 5'd0, 5'd0, 32'd0, 7'd0, 1'b1,
      '{8'd1, 1'b0, 1'b1, 32'd0, 4'd0, ERR_NONE}},
    '{ACT_POP, 5'd31, 5'd0, 5'd0, 32'd0, 7'd5, 1'b1,
      '{8'd6, 1'b0, 1'b0, 32'd0, 4'd0, ERR_EMPTY}},
    // jump targets: zero, negative, above the limit, both ends of the range
    '{ACT_JUMP, 5'd0, 5'd0, 5'd0, 32'd0, 7'd3, 1'b1,
      '{8'd4, 1'b0, 1'b0, 32'd0, 4'd0, ERR_JUMP}},
    '{ACT_JUMP, 5'd0, 5'd0, 5'd0, W_MIN, 7'd7, 1'b1,
      '{8'd8, 1'b0, 1'b0, 32'd0, 4'd0, ERR_JUMP}},
    '{ACT_JUMP, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, 7'd126, 1'b1,
      '{8'd127, 1'b0, 1'b0, 32'd0, 4'd0, ERR_JUMP}},
    '{ACT_JUMP, 5'd0, 5'd0, 5'd0, 32'd128, 7'd0, 1'b1,
      '{8'd127, 1'b0, 1'b0, 32'd0, 4'd0, ERR_NONE}},
    '{ACT_JUMP, 5'd0, 5'd0, 5'd0, 32'd129, 7'd0, 1'b1,
      '{8'd1, 1'b0, 1'b0, 32'd0, 4'd0, ERR_JUMP}},
    '{ACT_JUMP, 5'd0, 5'd0, 5'd0, 32'd1, 7'd100, 1'b1,
      '{8'd0, 1'b0, 1'b0, 32'd0, 4'd0, ERR_NONE}},
    // signed overflow both ways, then logic ops keep the overflow flag
    '{ACT_MOVIMM, 5'd1, 5'd0, 5'd0, W_MAX, 7'd127, 1'b1,
      '{8'd128, 1'b0, 1'b0, 32'd0, 4'd0, ERR_NONE}},
    '{ACT_ADDI, 5'd2, 5'd1, 5'd0, 32'd1, 7'd10, 1'b1,
      '{8'd11, 1'b0, 1'b0, 32'd0, F_PAR | F_NEG | F_OVF, ERR_NONE}},
    '{ACT_SUBI, 5'd3, 5'd2, 5'd0, 32'd1, 7'd11, 1'b1,
      '{8'd12, 1'b0, 1'b0, 32'd0, F_PAR | F_OVF, ERR_NONE}},
    '{ACT_AND, 5'd4, 5'd1, 5'd2, 32'd0, 7'd12, 1'b1,
      '{8'd13, 1'b0, 1'b0, 32'd0, F_ZERO | F_OVF, ERR_NONE}},
    '{ACT_XOR, 5'd5, 5'd1, 5'd2, 32'd0, 7'd13, 1'b1,
      '{8'd14, 1'b0, 1'b0, 32'd0, F_NEG | F_OVF, ERR_NONE}},
    // the rest go through the executor
    '{ACT_ADD, 5'd7, 5'd5, 5'd5, 32'd0, 7'd14, 1'b0, '0},
    '{ACT_SUB, 5'd8, 5'd2, 5'd1, 32'd0, 7'd15, 1'b0, '0},
    '{ACT_OR, 5'd9, 5'd3, 5'd2, 32'd0, 7'd16, 1'b0, '0},
    '{ACT_ANDI, 5'd10, 5'd5, 5'd0, 32'h0F0F_0F0F, 7'd17, 1'b0, '0},
    '{ACT_XORI, 5'd11, 5'd11, 5'd0, 32'hFFFF_FFFF, 7'd18, 1'b0, '0},
    '{ACT_ORI, 5'd12, 5'd0, 5'd0, W_MIN, 7'd19, 1'b0, '0},
    '{ACT_SWAP, 5'd1, 5'd2, 5'd0, 32'd0, 7'd20, 1'b0, '0},
    '{ACT_SKIPEQ, 5'd0, 5'd6, 5'd0, 32'd0, 7'd127, 1'b0, '0},
    '{ACT_SKIPEQ, 5'd1, 5'd2, 5'd0, 32'd0, 7'd21, 1'b0, '0},
    '{ACT_PUSH, 5'd5, 5'd0, 5'd0, 32'd0, 7'd30, 1'b0, '0},
    '{ACT_POP, 5'd13, 5'd0, 5'd0, 32'd0, 7'd31, 1'b0, '0},
    '{ACT_ADD, 5'd5, 5'd5, 5'd5, 32'd0, 7'd32, 1'b0, '0},
    '{ACT_INPUT, 5'd0, 5'd0, 5'd0, W_MIN, 7'd33, 1'b0, '0},
    '{ACT_OUTPUT, 5'd0, 5'd0, 5'd0, 32'd0, 7'd34, 1'b0, '0},
    '{ACT_EXIT, 5'd0, 5'd0, 5'd0, 32'd0, 7'd42, 1'b0, '0}
  };

  // parity, zero and negative of an alu result
  function automatic logic [FLAGS_W-1:0] value_flags(word_t v);
    logic [FLAGS_W-1:0] f;
    f = '0;
    f[FLAG_PAR]  = ^v;
    f[FLAG_ZERO] = (v == '0);
    f[FLAG_NEG]  = v[WORD_W-1];
    return f;
  endfunction

  // executes one instruction on the bench state and returns its outcome
  function automatic outcome_t run_instr(logic [ACTION_W-1:0] act,
                                         logic [REG_IDX_W-1:0] d,
                                         logic [REG_IDX_W-1:0] s,
                                         logic [REG_IDX_W-1:0] s2,
                                         word_t imm, logic [LINE_W-1:0] line);
    outcome_t o;
    word_t a, b, r;
    int limit;
    a = gpr[s];
    b = (act >= ACT_ADDI && act <= ACT_ORI) ? imm : gpr[s2];
    o = '0;
    o.next_line = NEXT_W'(line) + 8'd1;
    o.err = ERR_NONE;
    case (act)
      ACT_ADD, ACT_ADDI: begin
        r = a + b;
        gpr[d] = r;
        sr_flags = value_flags(r);
        sr_flags[FLAG_OVF] = (a[WORD_W-1] ^ r[WORD_W-1]) & (b[WORD_W-1] ^ r[WORD_W-1]);
      end
      ACT_SUB, ACT_SUBI: begin
        r = a - b;
        gpr[d] = r;
        sr_flags = value_flags(r);
        sr_flags[FLAG_OVF] = (a[WORD_W-1] ^ b[WORD_W-1]) & (a[WORD_W-1] ^ r[WORD_W-1]);
      end
      ACT_AND, ACT_ANDI, ACT_XOR, ACT_XORI, ACT_OR, ACT_ORI: begin
        if (act == ACT_AND || act == ACT_ANDI) r = a & b;
        else if (act == ACT_XOR || act == ACT_XORI) r = a ^ b;
        else r = a | b;
        gpr[d] = r;
        // logic ops leave overflow alone
        sr_flags = value_flags(r) | (sr_flags & F_OVF);
      end
      ACT_SWAP: begin
        r = gpr[d];
        gpr[d] = gpr[s];
        gpr[s] = r;
      end
      ACT_SKIPEQ: begin
        if (gpr[d] == gpr[s]) begin
          o.next_line = NEXT_W'(line) + 8'd2;
          n_skip++;
        end
      end
      ACT_PUSH: begin
        if (stk_cnt >= STACK_DEPTH) begin
          o.err = ERR_FULL;
        end else begin
          stk_mem[stk_cnt] = gpr[d];
          stk_cnt++;
        end
      end
      ACT_POP: begin
        if (stk_cnt == 0) begin
          o.err = ERR_EMPTY;
        end else begin
          stk_cnt--;
          gpr[d] = stk_mem[stk_cnt];
        end
      end
      ACT_MOVREG: gpr[d] = gpr[s];
      ACT_MOVIMM: gpr[d] = imm;
      ACT_JUMP: begin
        limit = (line_limit > MAX_LINES) ? MAX_LINES : int'(line_limit);
        if (imm[WORD_W-1] || imm == '0 || imm > word_t'(limit)) o.err = ERR_JUMP;
        else o.next_line = NEXT_W'(imm - 32'd1);
      end
      ACT_INPUT: gpr[0] = imm;
      ACT_OUTPUT: begin
        o.shows = 1'b1;
        o.value = gpr[0];
      end
      ACT_EXIT: begin
        o.halt = 1'b1;
        o.next_line = NEXT_W'(line);
      end
      default: ;
    endcase
    o.flags = sr_flags;
    return o;
  endfunction

  // gap or stall length for one item
  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bench state after reset
  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    foreach (stk_mem[i]) stk_mem[i] = '0;
    sr_flags   = '0;
    stk_cnt    = 0;
    line_limit = PLINES_RESET;
  end

  // run time guard
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc,
               pending_outcomes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) line_limit = cfg_program_lines;
      if (in_valid && in_ready) begin
        want = run_instr(in_action, in_dest_reg, in_src_reg, in_src2_reg,
                         in_immediate, in_line_index);
        // typed table outcome takes the place of the executor's
        if (row_known) want = row_res;
        case (want.err)
          ERR_FULL:  n_full++;
          ERR_EMPTY: n_empty++;
          ERR_JUMP:  n_jerr++;
          default: ;
        endcase
        if (want.halt) n_halt++;
        pending_outcomes.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{out_next_line, out_halt, out_shows_value, out_out_value,
                out_flags, out_error_code};
        if (pending_outcomes.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result: next %0d", got.next_line);
        end else begin
          want = pending_outcomes.pop_front();
          n_checked++;
          if (got.next_line !== want.next_line || got.halt !== want.halt ||
              got.shows !== want.shows || got.value !== want.value ||
              got.flags !== want.flags || got.err !== want.err) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"mismatch on result %0d: next %0d/%0d halt %0b/%0b ",
                        "shows %0b/%0b value %h/%h flags %h/%h err %0d/%0d ",
                        "(expected/actual)"},
                       n_checked, want.next_line, got.next_line, want.halt,
                       got.halt, want.shows, got.shows, want.value, got.value,
                       want.flags, got.flags, want.err, got.err);
          end
        end
      end
    end
  end

  // result side: random stall before taking each result
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // offers one instruction item and holds it until taken
  task automatic send_item(logic [ACTION_W-1:0] act, logic [REG_IDX_W-1:0] d,
                           logic [REG_IDX_W-1:0] s, logic [REG_IDX_W-1:0] s2,
                           word_t imm, logic [LINE_W-1:0] line,
                           logic known, outcome_t res);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_dest_reg   <= d;
    in_src_reg    <= s;
    in_src2_reg   <= s2;
    in_immediate  <= imm;
    in_line_index <= line;
    row_known     <= known;
    row_res       <= res;
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // lets every outstanding result come back before a register write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register index: mostly a few low registers so compares and aliasing hit
  function automatic logic [REG_IDX_W-1:0] pick_reg();
    return ($urandom_range(0, 2) == 0) ? REG_IDX_W'($urandom_range(0, 31))
                                        : REG_IDX_W'($urandom_range(0, 3));
  endfunction

  function automatic word_t pick_imm(logic [ACTION_W-1:0] act, int plines);
    int sel;
    sel = $urandom_range(0, 9);
    if (act == ACT_JUMP && sel < 5) return word_t'($urandom_range(0, plines + 2));
    case (sel)
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 32'd1;
          2: return 32'hFFFF_FFFF;
          3: return W_MAX;
          default: return W_MIN;
        endcase
      end
      1, 2, 3, 4: return $urandom;
      default: return word_t'($urandom_range(0, 270)) - 32'd5;
    endcase
  endfunction

  // stack bias: 0 even mix, 1 mostly pushes (fills the stack), 2 mostly pops
  function automatic logic [ACTION_W-1:0] pick_action(int bias);
    int r;
    r = $urandom_range(0, 99);
    if (bias == 1 && r < 60) return ACT_PUSH;
    if (bias == 2 && r < 60) return ACT_POP;
    if ($urandom_range(0, 99) < 5)
      return ACTION_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
    return ACTION_W'($urandom_range(ACT_ADD, ACT_EXIT));
  endfunction

  // stimulus
  initial begin
    int phase_lines [NUM_PHASES];
    int phase_bias [NUM_PHASES];
    logic [ACTION_W-1:0] act;
    rst_n             <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_program_lines <= '0;
    in_valid          <= 1'b0;
    in_action         <= '0;
    in_dest_reg       <= '0;
    in_src_reg        <= '0;
    in_src2_reg       <= '0;
    in_immediate      <= '0;
    in_line_index     <= '0;
    row_known         <= 1'b0;
    row_res           <= '0;
    steady            = 1'b0;
    // program lengths: one, above the line cap, the cap, zero, tiny, random
    phase_lines = '{1, 255, 128, 0, 2, $urandom_range(3, 127)};
    phase_bias  = '{0, 1, 0, 2, 0, 1};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table with program_lines at its reset value
    foreach (instr_rows[i])
      send_item(instr_rows[i].act, instr_rows[i].dst, instr_rows[i].src,
                instr_rows[i].src2, instr_rows[i].imm, instr_rows[i].line,
                instr_rows[i].known, instr_rows[i].res);

    // random phases, each with its own program length
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      cfg_valid         <= 1'b1;
      cfg_program_lines <= PLINES_W'(phase_lines[p]);
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // alternate runs of back-to-back traffic with random gaps
        if (k % 48 == 0) steady = ($urandom_range(0, 3) == 0);
        act = pick_action(phase_bias[p]);
        send_item(act, pick_reg(), pick_reg(), pick_reg(),
                  pick_imm(act, phase_lines[p]),
                  LINE_W'($urandom_range(0, 127)), 1'b0, '0);
      end
    end
    steady = 1'b0;
    drain();
    repeat (8) @(posedge clk);

    $display("%0d instructions issued over %0d program lengths, %0d results compared",
             n_sent, NUM_PHASES + 1, n_checked);
    $display("stack full %0d, stack empty %0d, bad jumps %0d, skips %0d, exits %0d",
             n_full, n_empty, n_jerr, n_skip, n_halt);
    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatching results", n_bad);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/trm_pkg.sv
src/trm_ram.sv
src/trm_alu.sv
src/trm_stack.sv
src/toy_register_machine_execute.sv
test/tb.sv
